// ===== hdl/pixel_downscale_2x_filter_defines.svh =====
// Assertion macros shared by the 2x downscale filter RTL.
`ifndef PIXEL_DOWNSCALE_2X_FILTER_DEFINES_SVH
`define PIXEL_DOWNSCALE_2X_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is active
`define PD2X_ASSERT_IMPLY(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error("pd2x assertion failed");
// Next-cycle implication, disabled while reset is active
`define PD2X_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error("pd2x assertion failed");
`else
`define PD2X_ASSERT_IMPLY(label, clk_sig, rst_n_sig, ante, cons)
`define PD2X_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons)
`endif
`endif

// ===== hdl/pd2x_pkg.sv =====
// Shared types, codes and helper functions of the 2x downscale filter.
package pd2x_pkg;

	// Edge codes for column_edge and row_edge
	localparam logic [1:0] EDGE_NONE  = 2'd0;
	localparam logic [1:0] EDGE_FIRST = 2'd1;
	localparam logic [1:0] EDGE_LAST  = 2'd2;

	// filter_axes codes; the unused code behaves as two-dimensional
	localparam logic [1:0] AXES_2D    = 2'd0;
	localparam logic [1:0] AXES_HORIZ = 2'd1;
	localparam logic [1:0] AXES_VERT  = 2'd2;

	// Control that travels alongside the divide-by-7 stages
	typedef struct packed {
		logic       valid;
		logic [1:0] sevens;	// number of factors of 7 in the divisor
	} div_ctrl_t;

	// 1,3,3,1 tap weight with the missing edge tap zeroed
	function automatic logic [1:0] tap_weight(input logic [1:0] edge_code,
		input logic [1:0] tap);
		logic [1:0] w;
		w = (tap == 2'd0 || tap == 2'd3) ? 2'd1 : 2'd3;
		if (edge_code == EDGE_FIRST && tap == 2'd0) begin
			w = 2'd0;
		end
		if (edge_code == EDGE_LAST && tap == 2'd3) begin
			w = 2'd0;
		end
		return w;
	endfunction

	// Half the divisor 8^eights * 7^sevens, used for round-to-nearest
	function automatic logic [5:0] round_offset(input logic [1:0] eights,
		input logic [1:0] sevens);
		logic [5:0] ofs;
		unique case ({eights, sevens})
			{2'd2, 2'd0}: ofs = 6'd32;
			{2'd1, 2'd1}: ofs = 6'd28;
			{2'd0, 2'd2}: ofs = 6'd24;
			{2'd1, 2'd0}: ofs = 6'd4;
			{2'd0, 2'd1}: ofs = 6'd3;
			default:      ofs = 6'd0;
		endcase
		return ofs;
	endfunction

endpackage

// ===== hdl/pd2x_div7.sv =====
// Registered divide-by-7 stage with bypass, using an exact reciprocal multiply.
`include "pixel_downscale_2x_filter_defines.svh"

module pd2x_div7 #(
	parameter int W    = 14,
	parameter int STEP = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pd2x_pkg::div_ctrl_t ctrl_in,
	input  logic [W-1:0]        x,
	output pd2x_pkg::div_ctrl_t ctrl_out,
	output logic [W-1:0]        q
);

	// K = W + 3 with a rounded-up reciprocal gives floor(x/7) exactly for x < 2^W
	localparam int K  = W + 3;
	localparam int RW = W + 3;
	localparam logic [W:0] RECIP = (W + 1)'(((64'd1 << K) + 64'd6) / 64'd7);
	localparam logic [1:0] STEP_CODE = 2'(STEP);

	logic [2*W:0]        prod;
	logic [W-1:0]        q_d;
	logic                bypass;
	pd2x_pkg::div_ctrl_t ctrl_q;
	logic [W-1:0]        q_q;

	// this stage divides only when the divisor still holds a factor of 7 for it
	assign bypass = ctrl_in.sevens < STEP_CODE;
	assign prod   = (2*W + 1)'(x) * (2*W + 1)'(RECIP);
	assign q_d    = bypass ? x : W'(prod >> K);

	// control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else begin
			ctrl_q <= ctrl_in;
		end
	end

	// quotient register
	always_ff @(posedge clk) begin
		q_q <= q_d;
	end

	assign ctrl_out = ctrl_q;
	assign q        = q_q;

	`PD2X_ASSERT_NEXT(a_div_bypass, clk, arst_n, ctrl_in.valid && bypass, q == $past(x))
	`PD2X_ASSERT_NEXT(a_div_quotient, clk, arst_n, ctrl_in.valid && !bypass, (RW'(q) * RW'(7) <= RW'($past(x))) && (RW'($past(x)) < RW'(q) * RW'(7) + RW'(7)))

endmodule

// ===== hdl/pixel_downscale_2x_filter.sv =====
// Top level of the 2x downscale filter: 4x4 window in, one rounded sample out.
// Path from an accepted request (start high) to the done strobe: request register, row-sum,
// window-sum, two divide-by-7 multiply stages and the result register.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Reset clears the pipeline valid flags and sets filter_axes to two-dimensional.
// The receiver cannot stall: each result shows for one cycle with done high.
`include "pixel_downscale_2x_filter_defines.svh"

module pixel_downscale_2x_filter #(
	parameter int SAMPLE_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] row_top,
	input  logic [31:0] row_second,
	input  logic [31:0] row_third,
	input  logic [31:0] row_bottom,
	input  logic [1:0]  column_edge,
	input  logic [1:0]  row_edge,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_data,
	output logic        done,
	output logic [7:0]  filtered_sample
);

	localparam int HSUM_W = SAMPLE_BITS + 3;	// 8 * max sample
	localparam int SUM_W  = SAMPLE_BITS + 6;	// 64 * max sample + rounding

	logic [1:0] filter_axes_q;

	// stage 1: registered request
	logic             valid_s1;
	logic [3:0][31:0] rows_s1;
	logic [1:0]       column_edge_s1;
	logic [1:0]       row_edge_s1;
	logic [1:0]       axes_s1;

	// stage 2: weighted row sums
	logic                          valid_s2;
	logic [HSUM_W-1:0]             hsum_s2 [4];
	logic [1:0]                    roww_s2 [4];
	logic [1:0]                    eights_s2;
	logic [1:0]                    sevens_s2;

	// stage 3: rounded window sum
	logic             valid_s3;
	logic [SUM_W-1:0] sum_s3;
	logic [1:0]       eights_s3;
	logic [1:0]       sevens_s3;

	logic [1:0]        colw [4];
	logic [1:0]        roww [4];
	logic [HSUM_W-1:0] hsum [4];
	logic [1:0]        eights;
	logic [1:0]        sevens;
	logic              col_seven;
	logic              row_seven;
	logic [SUM_W-1:0]  sum_d;
	logic [SUM_W-1:0]  shifted;

	pd2x_pkg::div_ctrl_t ctrl_a;
	pd2x_pkg::div_ctrl_t ctrl_b;
	pd2x_pkg::div_ctrl_t ctrl_c;
	logic [SUM_W-1:0]    quot_a;
	logic [SUM_W-1:0]    quot_b;

	logic       done_q;
	logic [7:0] filtered_sample_q;

	assign busy = 1'b0;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_axes_q <= pd2x_pkg::AXES_2D;
		end else if (cfg_write) begin
			filter_axes_q <= cfg_data;
		end
	end

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		rows_s1[0]     <= row_top;
		rows_s1[1]     <= row_second;
		rows_s1[2]     <= row_third;
		rows_s1[3]     <= row_bottom;
		column_edge_s1 <= column_edge;
		row_edge_s1    <= row_edge;
		axes_s1        <= filter_axes_q;
	end

	// effective weights and divisor factors; one-axis modes collapse the other axis
	always_comb begin
		col_seven = (column_edge_s1 == pd2x_pkg::EDGE_FIRST) ||
			(column_edge_s1 == pd2x_pkg::EDGE_LAST);
		row_seven = (row_edge_s1 == pd2x_pkg::EDGE_FIRST) ||
			(row_edge_s1 == pd2x_pkg::EDGE_LAST);
		for (int k = 0; k < 4; k++) begin
			colw[k] = pd2x_pkg::tap_weight(column_edge_s1, 2'(k));
			roww[k] = pd2x_pkg::tap_weight(row_edge_s1, 2'(k));
		end
		unique case (axes_s1)
			pd2x_pkg::AXES_HORIZ: begin
				for (int k = 1; k < 4; k++) begin
					roww[k] = 2'd0;
				end
				roww[0] = 2'd1;
				eights  = {1'b0, ~col_seven};
				sevens  = {1'b0, col_seven};
			end
			pd2x_pkg::AXES_VERT: begin
				for (int k = 1; k < 4; k++) begin
					colw[k] = 2'd0;
				end
				colw[0] = 2'd1;
				eights  = {1'b0, ~row_seven};
				sevens  = {1'b0, row_seven};
			end
			default: begin
				eights = {1'b0, ~col_seven} + {1'b0, ~row_seven};
				sevens = {1'b0, col_seven} + {1'b0, row_seven};
			end
		endcase
	end

	// horizontal weighted sum of each row; samples past bit 31 read as zero
	always_comb begin
		logic [63:0] padded;
		for (int r = 0; r < 4; r++) begin
			padded  = {32'd0, rows_s1[r]};
			hsum[r] = '0;
			for (int c = 0; c < 4; c++) begin
				hsum[r] = hsum[r] + HSUM_W'(colw[c]) *
					HSUM_W'(padded[c*SAMPLE_BITS +: SAMPLE_BITS]);
			end
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			hsum_s2[r] <= hsum[r];
			roww_s2[r] <= roww[r];
		end
		eights_s2 <= eights;
		sevens_s2 <= sevens;
	end

	// vertical weighting plus half the divisor
	always_comb begin
		sum_d = SUM_W'(pd2x_pkg::round_offset(eights_s2, sevens_s2));
		for (int r = 0; r < 4; r++) begin
			sum_d = sum_d + SUM_W'(roww_s2[r]) * SUM_W'(hsum_s2[r]);
		end
	end

	// stage 3 payload
	always_ff @(posedge clk) begin
		sum_s3    <= sum_d;
		eights_s3 <= eights_s2;
		sevens_s3 <= sevens_s2;
	end

	// powers of two in the divisor come off as a shift
	always_comb begin
		unique case (eights_s3)
			2'd1:    shifted = sum_s3 >> 3;
			2'd2:    shifted = sum_s3 >> 6;
			default: shifted = sum_s3;
		endcase
	end

	assign ctrl_a = '{valid: valid_s3, sevens: sevens_s3};

	// two divide-by-7 stages cover divisors 7 and 49
	pd2x_div7 #(.W(SUM_W), .STEP(1)) u_div_first (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_in  (ctrl_a),
		.x        (shifted),
		.ctrl_out (ctrl_b),
		.q        (quot_a)
	);

	pd2x_div7 #(.W(SUM_W), .STEP(2)) u_div_second (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_in  (ctrl_b),
		.x        (quot_a),
		.ctrl_out (ctrl_c),
		.q        (quot_b)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_c.valid;
		end
	end

	// result sample; the quotient never exceeds the largest input sample
	always_ff @(posedge clk) begin
		filtered_sample_q <= 8'(quot_b);
	end

	assign done            = done_q;
	assign filtered_sample = filtered_sample_q;

	`PD2X_ASSERT_IMPLY(a_latency, clk, arst_n, start && !busy, ##6 done)
	`PD2X_ASSERT_IMPLY(a_result_range, clk, arst_n, done, (16'(filtered_sample) >> SAMPLE_BITS) == 16'd0)
	`PD2X_ASSERT_IMPLY(a_divisor_factors, clk, arst_n, valid_s3, (3'(eights_s3) + 3'(sevens_s3) == 3'd1) || (3'(eights_s3) + 3'(sevens_s3) == 3'd2))

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the 2x downscale filter: directed windows, then random requests.
`timescale 1ns / 100ps

module tb;

	localparam int PIPE_LATENCY = 6;
	localparam int ITEMS_PER_PHASE = 244;
	localparam int NUM_PHASES = 8;
	// Codes the package leaves unnamed; both behave like code zero
	localparam logic [1:0] AXES_SPARE = 2'd3;
	localparam logic [1:0] EDGE_SPARE = 2'd3;

	// One window request, with an optional hand-computed answer
	typedef struct packed {
		logic [1:0]  axes;
		logic [31:0] top;
		logic [31:0] second;
		logic [31:0] third;
		logic [31:0] bottom;
		logic [1:0]  col_edge;
		logic [1:0]  row_edge;
		logic        has_known;
		logic [7:0]  known_sample;
	} window_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [31:0] row_top = '0;
	logic [31:0] row_second = '0;
	logic [31:0] row_third = '0;
	logic [31:0] row_bottom = '0;
	logic [1:0]  column_edge = pd2x_pkg::EDGE_NONE;
	logic [1:0]  row_edge = pd2x_pkg::EDGE_NONE;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_data = pd2x_pkg::AXES_2D;
	logic        done;
	logic [7:0]  filtered_sample;

	logic [1:0]  axes_setting = pd2x_pkg::AXES_2D;
	logic [7:0]  expected_samples [$];
	int          mismatch_count = 0;

	logic [1:0] phase_axes [NUM_PHASES - 1] = '{pd2x_pkg::AXES_2D, pd2x_pkg::AXES_HORIZ,
		pd2x_pkg::AXES_VERT, AXES_SPARE, pd2x_pkg::AXES_VERT, pd2x_pkg::AXES_HORIZ,
		pd2x_pkg::AXES_2D};

	// Directed windows: extremes, every mode and both unused codes
	window_req_t directed_reqs [24] = '{
		'{pd2x_pkg::AXES_2D, 32'h0, 32'h0, 32'h0, 32'h0,
			pd2x_pkg::EDGE_NONE, pd2x_pkg::EDGE_NONE, 1'b1, 8'd0},
		'{pd2x_pkg::AXES_2D, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			pd2x_pkg::EDGE_NONE, pd2x_pkg::EDGE_NONE, 1'b1, 8'd255},
		'{pd2x_pkg::AXES_2D, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			pd2x_pkg::EDGE_FIRST, pd2x_pkg::EDGE_FIRST, 1'b1, 8'd255},
		'{pd2x_pkg::AXES_2D, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			pd2x_pkg::EDGE_LAST, pd2x_pkg::EDGE_LAST, 1'b1, 8'd255},
		'{pd2x_pkg::AXES_2D, 32'h80808080, 32'h80808080, 32'h80808080, 32'h80808080,
			EDGE_SPARE, EDGE_SPARE, 1'b1, 8'd128},
		'{pd2x_pkg::AXES_2D, 32'h01010101, 32'h01010101, 32'h01010101, 32'h01010101,
			pd2x_pkg::EDGE_FIRST, pd2x_pkg::EDGE_LAST, 1'b1, 8'd1},
		'{pd2x_pkg::AXES_2D, 32'h000000FF, 32'h0, 32'h0, 32'h0,
			pd2x_pkg::EDGE_NONE, pd2x_pkg::EDGE_NONE, 1'b0, 8'd0},
		'{pd2x_pkg::AXES_2D, 32'h000000FF, 32'h0, 32'h0, 32'h0,
			pd2x_pkg::EDGE_FIRST, pd2x_pkg::EDGE_FIRST, 1'b1, 8'd0},
		'{pd2x_pkg::AXES_2D, 32'h0, 32'h0, 32'h0, 32'hFF000000,
			pd2x_pkg::EDGE_LAST, pd2x_pkg::EDGE_LAST, 1'b1, 8'd0},
		'{pd2x_pkg::AXES_2D, 32'h00FF00FF, 32'hFF00FF00, 32'h00FF00FF, 32'hFF00FF00,
			pd2x_pkg::EDGE_NONE, pd2x_pkg::EDGE_NONE, 1'b0, 8'd0},
		'{pd2x_pkg::AXES_2D, 32'h12345678, 32'h9ABCDEF0, 32'h0F1E2D3C, 32'h4B5A6978,
			pd2x_pkg::EDGE_LAST, pd2x_pkg::EDGE_FIRST, 1'b0, 8'd0},
		'{pd2x_pkg::AXES_2D, 32'hFFFFFFFE, 32'h7F80FE01, 32'h00FF7F80, 32'hC3A55A3C,
			EDGE_SPARE, pd2x_pkg::EDGE_NONE, 1'b0, 8'd0},
		'{pd2x_pkg::AXES_HORIZ, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h0,
			pd2x_pkg::EDGE_NONE, pd2x_pkg::EDGE_NONE, 1'b1, 8'd255},
		'{pd2x_pkg::AXES_HORIZ, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			pd2x_pkg::EDGE_NONE, pd2x_pkg::EDGE_LAST, 1'b1, 8'd0},
		'{pd2x_pkg::AXES_HORIZ, 32'h01020304, 32'hFFFFFFFF, 32'h0, 32'hA5A5A5A5,
			pd2x_pkg::EDGE_FIRST, pd2x_pkg::EDGE_LAST, 1'b0, 8'd0},
		'{pd2x_pkg::AXES_HORIZ, 32'hFF000000, 32'h0, 32'h0, 32'h0,
			pd2x_pkg::EDGE_LAST, pd2x_pkg::EDGE_FIRST, 1'b1, 8'd0},
		'{pd2x_pkg::AXES_HORIZ, 32'h80FF7F01, 32'h11111111, 32'h22222222, 32'h33333333,
			EDGE_SPARE, EDGE_SPARE, 1'b0, 8'd0},
		'{pd2x_pkg::AXES_VERT, 32'h000000FF, 32'h000000FF, 32'h000000FF, 32'h000000FF,
			pd2x_pkg::EDGE_NONE, pd2x_pkg::EDGE_NONE, 1'b1, 8'd255},
		'{pd2x_pkg::AXES_VERT, 32'hFFFFFF00, 32'hFFFFFF00, 32'hFFFFFF00, 32'hFFFFFF00,
			pd2x_pkg::EDGE_LAST, pd2x_pkg::EDGE_FIRST, 1'b1, 8'd0},
		'{pd2x_pkg::AXES_VERT, 32'h000000FF, 32'h0, 32'h0, 32'h0,
			pd2x_pkg::EDGE_LAST, pd2x_pkg::EDGE_FIRST, 1'b1, 8'd0},
		'{pd2x_pkg::AXES_VERT, 32'hFFFFFF10, 32'h00000020, 32'hAB000030, 32'h000000F0,
			pd2x_pkg::EDGE_NONE, pd2x_pkg::EDGE_LAST, 1'b0, 8'd0},
		'{pd2x_pkg::AXES_VERT, 32'h000000FE, 32'h00000001, 32'h0000007F, 32'h00000080,
			pd2x_pkg::EDGE_FIRST, EDGE_SPARE, 1'b0, 8'd0},
		'{AXES_SPARE, 32'h55555555, 32'h55555555, 32'h55555555, 32'h55555555,
			pd2x_pkg::EDGE_FIRST, pd2x_pkg::EDGE_LAST, 1'b1, 8'h55},
		'{AXES_SPARE, 32'hDEADBEEF, 32'h01234567, 32'h89ABCDEF, 32'hFEDCBA98,
			pd2x_pkg::EDGE_NONE, pd2x_pkg::EDGE_NONE, 1'b0, 8'd0}
	};

	pixel_downscale_2x_filter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.row_top         (row_top),
		.row_second      (row_second),
		.row_third       (row_third),
		.row_bottom      (row_bottom),
		.column_edge     (column_edge),
		.row_edge        (row_edge),
		.cfg_write       (cfg_write),
		.cfg_data        (cfg_data),
		.done            (done),
		.filtered_sample (filtered_sample)
	);

	always #5 clk = ~clk;

	// 1,3,3,1 taps per axis, with the missing edge tap zeroed
	function automatic logic [3:0][1:0] edge_taps(input logic [1:0] edge_code);
		logic [3:0][1:0] w;
		w[0] = 2'd1;
		w[1] = 2'd3;
		w[2] = 2'd3;
		w[3] = 2'd1;
		if (edge_code == pd2x_pkg::EDGE_FIRST) begin
			w[0] = 2'd0;
		end else if (edge_code == pd2x_pkg::EDGE_LAST) begin
			w[3] = 2'd0;
		end
		return w;
	endfunction

	// Rounded weighted average of the window under the given axes mode
	function automatic logic [7:0] downscaled_sample(input logic [1:0] axes,
		input window_req_t req);
		logic [3:0][1:0]  cw;
		logic [3:0][1:0]  rw;
		logic [3:0][31:0] rows;
		int unsigned      col_sum;
		int unsigned      row_sum;
		int unsigned      acc;
		int unsigned      divisor;
		cw = edge_taps(req.col_edge);
		rw = edge_taps(req.row_edge);
		rows[0] = req.top;
		rows[1] = req.second;
		rows[2] = req.third;
		rows[3] = req.bottom;
		col_sum = 0;
		row_sum = 0;
		acc = 0;
		for (int k = 0; k < 4; k++) begin
			col_sum += cw[k];
			row_sum += rw[k];
		end
		if (axes == pd2x_pkg::AXES_HORIZ) begin
			for (int c = 0; c < 4; c++)
				acc += cw[c] * rows[0][8*c +: 8];
			divisor = col_sum;
		end else if (axes == pd2x_pkg::AXES_VERT) begin
			for (int r = 0; r < 4; r++)
				acc += rw[r] * rows[r][7:0];
			divisor = row_sum;
		end else begin
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 4; c++)
					acc += rw[r] * cw[c] * rows[r][8*c +: 8];
			divisor = col_sum * row_sum;
		end
		return 8'((acc + divisor / 2) / divisor);
	endfunction

	// Mostly random words, with extremes and repeated bytes mixed in
	function automatic logic [31:0] random_row();
		logic [7:0] b;
		b = 8'($urandom);
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hFFFFFFFF;
			2: return {4{b}};
			default: return $urandom;
		endcase
	endfunction

	// Drive one request and hold it until accepted, then log the expected sample
	task automatic issue_window(input window_req_t req);
		row_top <= req.top;
		row_second <= req.second;
		row_third <= req.third;
		row_bottom <= req.bottom;
		column_edge <= req.col_edge;
		row_edge <= req.row_edge;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (req.has_known)
			expected_samples.push_back(req.known_sample);
		else
			expected_samples.push_back(downscaled_sample(axes_setting, req));
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Let the pipeline empty, then write the mode register
	task automatic apply_filter_axes(input logic [1:0] value);
		start <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		axes_setting = value;
		cfg_write <= 1'b0;
	endtask

	// Compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_samples.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result %0d", $realtime, filtered_sample);
			end else begin
				if (filtered_sample !== expected_samples[0]) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: filtered_sample expected %0d got %0d", $realtime,
							expected_samples[0], filtered_sample);
				end
				void'(expected_samples.pop_front());
			end
		end
	end

	// Stimulus
	initial begin
		int          guard;
		window_req_t req;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apply_filter_axes(pd2x_pkg::AXES_2D);
		foreach (directed_reqs[i]) begin
			if (directed_reqs[i].axes != axes_setting)
				apply_filter_axes(directed_reqs[i].axes);
			issue_window(directed_reqs[i]);
		end

		// Random phases; the last one uses a random mode and never idles
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase == NUM_PHASES - 1)
				apply_filter_axes(2'($urandom_range(0, 3)));
			else
				apply_filter_axes(phase_axes[phase]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase != NUM_PHASES - 1 && (n / 40) % 2 == 0 && $urandom_range(0, 3) == 0)
					idle_cycles($urandom_range(1, 15));
				req.axes = axes_setting;
				req.top = random_row();
				req.second = random_row();
				req.third = random_row();
				req.bottom = random_row();
				req.col_edge = 2'($urandom_range(0, 3));
				req.row_edge = 2'($urandom_range(0, 3));
				req.has_known = 1'b0;
				req.known_sample = 8'd0;
				issue_window(req);
			end
		end

		// Drain, then watch a little longer for stray results
		start <= 1'b0;
		for (guard = 0; guard < 1000 && expected_samples.size() != 0; guard++)
			@(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
		if (mismatch_count == 0 && expected_samples.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
